[hdl/packed_list_entry_parser_defines.svh]
// Assertion macros for the packed list entry parser.
// Used by the checker; needs no other file.
`ifndef PACKED_LIST_ENTRY_PARSER_DEFINES_SVH
`define PACKED_LIST_ENTRY_PARSER_DEFINES_SVH

// same-cycle implication
`define PLEP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLEP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/plep_pkg.sv]
// Types and codes for the packed list entry parser.
// No dependencies; imported by every module of the block.
package plep_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [7:0]         payload_byte;
        logic signed [63:0] int_value;
        logic               string_end;
        logic [1:0]         error_code;
        logic [15:0]        entry_index;
        logic               run_last;
    } t_out;

    // up to two results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        t_out       item0;
        t_out       item1;
    } t_res_pair;

    localparam logic [2:0] KIND_STR_BYTE  = 3'd0;
    localparam logic [2:0] KIND_INT       = 3'd1;
    localparam logic [2:0] KIND_EMPTY_STR = 3'd2;
    localparam logic [2:0] KIND_LIST_DONE = 3'd3;
    localparam logic [2:0] KIND_ERROR     = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_ENC   = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_COUNT     = 2'd3;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_PREV,
        PH_PREVLONG,
        PH_ENC,
        PH_LEN,
        PH_INT,
        PH_STR
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  hdr_seen;
        logic [15:0] declared;
        logic [15:0] done;
        logic [3:0]  field_left;
        logic [63:0] acc;
        logic [31:0] str_left;
        logic [2:0]  int_code;
    } t_state;

    localparam t_state ST_CLEAR = '{
        phase:      PH_HDR,
        hdr_seen:   4'd0,
        declared:   16'd0,
        done:       16'd0,
        field_left: 4'd0,
        acc:        64'd0,
        str_left:   32'd0,
        int_code:   3'd0
    };

endpackage

[hdl/packed_list_entry_parser.sv]
// Top level of the packed list entry parser.
// Depends on plep_pkg, plep_decode and plep_out_fifo.
//
// Takes one buffer byte per cycle while o_in_ready is high. Each byte lands in
// an input register and is decoded against the parser state once the result
// queue has room; its results (none, one or two) go into a four-entry result
// queue that drains one item per cycle while the consumer is ready. A byte that
// gives two results (an entry plus list complete, or an entry plus truncation
// error) writes both into the queue at once, so the input stalls only when the
// queue cannot take two more results.
module packed_list_entry_parser import plep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_in       r_in;
    logic      r_in_valid;
    t_state    r_state;
    logic      n_in_valid;
    t_state    n_state;
    t_res_pair dec_res;
    t_res_pair push;
    logic      fifo_room;
    logic      proc;

    assign proc       = r_in_valid && fifo_room;
    assign o_in_ready = !r_in_valid || proc;
    assign n_in_valid = (i_in_valid && o_in_ready) || (r_in_valid && !proc);

    plep_decode u_decode (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (dec_res)
    );

    always_comb begin
        push = dec_res;
        if (!proc) begin
            push.count = 2'd0;
        end
    end

    plep_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (fifo_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ST_CLEAR;
        end else begin
            r_in_valid <= n_in_valid;
            if (proc) begin
                r_state <= n_state;
            end
        end
    end

endmodule

[hdl/plep_decode.sv]
// Per-byte decode: next parser state and the results caused by one item.
// Pure combinational; depends on plep_pkg.
module plep_decode import plep_pkg::*; (
    input  t_state    i_state,
    input  t_in       i_item,
    output t_state    o_state,
    output t_res_pair o_res
);

    localparam logic [7:0] ENC_STR_LIMIT = 8'hC0;
    localparam logic [7:0] ENC_STR_MASK  = 8'hC0;
    localparam logic [7:0] ENC_STR6      = 8'h00;
    localparam logic [7:0] ENC_STR14     = 8'h40;
    localparam logic [7:0] ENC_LEN6_MASK = 8'h3F;
    localparam logic [7:0] ENC_INT8      = 8'hFE;
    localparam logic [7:0] ENC_INT16     = 8'hC0;
    localparam logic [7:0] ENC_INT24     = 8'hF0;
    localparam logic [7:0] ENC_INT32     = 8'hD0;
    localparam logic [7:0] ENC_INT64     = 8'hE0;
    localparam logic [7:0] ENC_IMM_LO    = 8'hF1;
    localparam logic [7:0] ENC_IMM_HI    = 8'hFD;
    localparam logic [7:0] END_MARK      = 8'hFF;
    localparam logic [7:0] PREV_LONG     = 8'hFE;

    localparam logic [3:0] HDR_LEN    = 4'd10;
    localparam logic [3:0] HDR_CNT_LO = 4'd8;
    localparam logic [3:0] HDR_CNT_HI = 4'd9;

    localparam logic [2:0] IW_8  = 3'd0;
    localparam logic [2:0] IW_16 = 3'd1;
    localparam logic [2:0] IW_24 = 3'd2;
    localparam logic [2:0] IW_32 = 3'd3;
    localparam logic [2:0] IW_64 = 3'd4;

    logic [7:0]  b;
    logic        last;
    logic [15:0] done_inc;
    logic [3:0]  hdr_inc;
    logic        hdr_done;
    logic [15:0] declared_next;
    logic [3:0]  fl_dec;
    logic [31:0] acc_len;
    logic [31:0] str_dec;
    logic [3:0]  int_total;
    logic [3:0]  pos_full;
    logic [63:0] acc_int;
    logic [63:0] int_sext;
    logic [63:0] imm_val;
    logic        is_int_start;

    logic        ent_emit;
    logic [2:0]  ent_kind;
    logic [7:0]  ent_pay;
    logic [63:0] ent_val;
    logic        ent_send;
    logic        fin;
    logic        err;
    logic [1:0]  err_code;
    logic        hdr_empty;
    logic        list_done;
    logic        terminal;
    logic        trunc;
    logic [15:0] trunc_idx;

    assign b         = i_item.data_byte;
    assign last      = i_item.buffer_end;
    assign done_inc  = i_state.done + 16'd1;
    assign hdr_inc   = i_state.hdr_seen + 4'd1;
    assign hdr_done  = (hdr_inc >= HDR_LEN);
    assign fl_dec    = i_state.field_left - {3'd0, i_state.field_left != 4'd0};
    assign acc_len   = {i_state.acc[23:0], b};
    assign str_dec   = i_state.str_left - {31'd0, i_state.str_left != 32'd0};
    assign pos_full  = int_total - i_state.field_left;
    assign imm_val   = {60'd0, b[3:0]} - 64'd1;
    assign is_int_start = (b == ENC_INT8) || (b == ENC_INT16) || (b == ENC_INT24)
                       || (b == ENC_INT32) || (b == ENC_INT64);

    always_comb begin
        declared_next = i_state.declared;
        if (i_state.hdr_seen == HDR_CNT_LO) begin
            declared_next = {8'd0, b};
        end else if (i_state.hdr_seen == HDR_CNT_HI) begin
            declared_next = {b, i_state.declared[7:0]};
        end
    end

    always_comb begin
        case (i_state.int_code)
            IW_8:    int_total = 4'd1;
            IW_16:   int_total = 4'd2;
            IW_24:   int_total = 4'd3;
            IW_32:   int_total = 4'd4;
            default: int_total = 4'd8;
        endcase
    end

    // little-endian byte lane insert
    always_comb begin
        acc_int = i_state.acc;
        for (int k = 0; k < 8; k++) begin
            if (pos_full[2:0] == 3'(k)) begin
                acc_int[8*k +: 8] = i_state.acc[8*k +: 8] | b;
            end
        end
    end

    always_comb begin
        case (i_state.int_code)
            IW_8:    int_sext = {{56{acc_int[7]}},  acc_int[7:0]};
            IW_16:   int_sext = {{48{acc_int[15]}}, acc_int[15:0]};
            IW_24:   int_sext = {{40{acc_int[23]}}, acc_int[23:0]};
            IW_32:   int_sext = {{32{acc_int[31]}}, acc_int[31:0]};
            default: int_sext = acc_int;
        endcase
    end

    // events of this byte
    always_comb begin
        ent_emit  = 1'b0;
        ent_kind  = KIND_STR_BYTE;
        ent_pay   = 8'd0;
        ent_val   = 64'd0;
        ent_send  = 1'b0;
        fin       = 1'b0;
        err       = 1'b0;
        err_code  = ERR_NONE;
        hdr_empty = 1'b0;
        case (i_state.phase)
            PH_HDR: begin
                hdr_empty = hdr_done && (declared_next == 16'd0);
            end
            PH_PREV: begin
                if (b == END_MARK) begin
                    err      = 1'b1;
                    err_code = ERR_COUNT;
                end
            end
            PH_ENC: begin
                if (b < ENC_STR_LIMIT) begin
                    if (((b & ENC_STR_MASK) == ENC_STR6) && ((b & ENC_LEN6_MASK) == 8'd0)) begin
                        ent_emit = 1'b1;
                        ent_kind = KIND_EMPTY_STR;
                        fin      = 1'b1;
                    end
                end else if (is_int_start) begin
                    ent_emit = 1'b0;
                end else if ((b >= ENC_IMM_LO) && (b <= ENC_IMM_HI)) begin
                    ent_emit = 1'b1;
                    ent_kind = KIND_INT;
                    ent_val  = imm_val;
                    fin      = 1'b1;
                end else begin
                    err      = 1'b1;
                    err_code = ERR_BAD_ENC;
                end
            end
            PH_LEN: begin
                if ((fl_dec == 4'd0) && (acc_len == 32'd0)) begin
                    ent_emit = 1'b1;
                    ent_kind = KIND_EMPTY_STR;
                    fin      = 1'b1;
                end
            end
            PH_INT: begin
                if (fl_dec == 4'd0) begin
                    ent_emit = 1'b1;
                    ent_kind = KIND_INT;
                    ent_val  = int_sext;
                    fin      = 1'b1;
                end
            end
            PH_STR: begin
                ent_emit = 1'b1;
                ent_kind = KIND_STR_BYTE;
                ent_pay  = b;
                ent_send = (str_dec == 32'd0);
                fin      = (str_dec == 32'd0);
            end
            default: begin
                ent_emit = 1'b0;
            end
        endcase
    end

    assign list_done = fin && (done_inc == i_state.declared);
    assign terminal  = err || list_done || hdr_empty;
    assign trunc     = last && !terminal;
    assign trunc_idx = fin ? done_inc : i_state.done;

    // next state
    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            PH_HDR: begin
                o_state.hdr_seen = hdr_done ? 4'd0 : hdr_inc;
                o_state.declared = declared_next;
                if (hdr_done) begin
                    o_state.done  = 16'd0;
                    o_state.phase = PH_PREV;
                end
            end
            PH_PREV: begin
                if (b == PREV_LONG) begin
                    o_state.field_left = 4'd4;
                    o_state.phase      = PH_PREVLONG;
                end else begin
                    o_state.phase = PH_ENC;
                end
            end
            PH_PREVLONG: begin
                o_state.field_left = fl_dec;
                if (fl_dec == 4'd0) begin
                    o_state.phase = PH_ENC;
                end
            end
            PH_ENC: begin
                if (b < ENC_STR_LIMIT) begin
                    if ((b & ENC_STR_MASK) == ENC_STR6) begin
                        o_state.str_left = {26'd0, b[5:0]};
                        o_state.phase    = PH_STR;
                    end else if ((b & ENC_STR_MASK) == ENC_STR14) begin
                        o_state.acc        = {58'd0, b[5:0]};
                        o_state.field_left = 4'd1;
                        o_state.phase      = PH_LEN;
                    end else begin
                        o_state.acc        = 64'd0;
                        o_state.field_left = 4'd4;
                        o_state.phase      = PH_LEN;
                    end
                end else if (is_int_start) begin
                    o_state.acc   = 64'd0;
                    o_state.phase = PH_INT;
                    case (b)
                        ENC_INT8: begin
                            o_state.int_code   = IW_8;
                            o_state.field_left = 4'd1;
                        end
                        ENC_INT16: begin
                            o_state.int_code   = IW_16;
                            o_state.field_left = 4'd2;
                        end
                        ENC_INT24: begin
                            o_state.int_code   = IW_24;
                            o_state.field_left = 4'd3;
                        end
                        ENC_INT32: begin
                            o_state.int_code   = IW_32;
                            o_state.field_left = 4'd4;
                        end
                        default: begin
                            o_state.int_code   = IW_64;
                            o_state.field_left = 4'd8;
                        end
                    endcase
                end
            end
            PH_LEN: begin
                o_state.acc        = {32'd0, acc_len};
                o_state.field_left = fl_dec;
                if (fl_dec == 4'd0) begin
                    o_state.str_left = acc_len;
                    o_state.acc      = 64'd0;
                    o_state.phase    = PH_STR;
                end
            end
            PH_INT: begin
                o_state.acc        = acc_int;
                o_state.field_left = fl_dec;
                if (fl_dec == 4'd0) begin
                    o_state.acc = 64'd0;
                end
            end
            PH_STR: begin
                o_state.str_left = str_dec;
            end
            default: begin
                o_state = ST_CLEAR;
            end
        endcase
        if (fin) begin
            o_state.done  = done_inc;
            o_state.phase = PH_PREV;
        end
        if (terminal || trunc) begin
            o_state = ST_CLEAR;
        end
    end

    // results in order: entry, list complete, error, truncation
    always_comb begin
        t_out       cand [4];
        logic [3:0] cand_v;
        logic [2:0] n;
        cand[0]              = '0;
        cand[0].result_kind  = ent_kind;
        cand[0].payload_byte = ent_pay;
        cand[0].int_value    = ent_val;
        cand[0].string_end   = ent_send;
        cand[0].entry_index  = i_state.done;
        cand[1]              = '0;
        cand[1].result_kind  = KIND_LIST_DONE;
        cand[1].entry_index  = hdr_empty ? 16'd0 : done_inc;
        cand[2]              = '0;
        cand[2].result_kind  = KIND_ERROR;
        cand[2].error_code   = err_code;
        cand[2].entry_index  = i_state.done;
        cand[3]              = '0;
        cand[3].result_kind  = KIND_ERROR;
        cand[3].error_code   = ERR_TRUNCATED;
        cand[3].entry_index  = trunc_idx;
        cand_v = {trunc, err, list_done || hdr_empty, ent_emit};
        o_res  = '0;
        n      = 3'd0;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k]) begin
                if (n == 3'd0) begin
                    o_res.item0 = cand[k];
                end else if (n == 3'd1) begin
                    o_res.item1 = cand[k];
                end
                n = n + 3'd1;
            end
        end
        if (n == 3'd1) begin
            o_res.item0.run_last = 1'b1;
        end else if (n >= 3'd2) begin
            o_res.item1.run_last = 1'b1;
        end
        o_res.count = (n >= 3'd2) ? 2'd2 : n[1:0];
    end

endmodule

[hdl/plep_out_fifo.sv]
// Four-entry result queue: takes up to two results a cycle, gives one while i_ready is high.
// Depends on plep_pkg.
module plep_out_fifo import plep_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_pair i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out      o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_out          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_count - CW'(pop)) <= CW'(DEPTH - 2);

    assign n_wr_ptr = r_wr_ptr + AW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + AW'(pop);
    assign n_count  = r_count + CW'(i_push.count) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hdl/plep_checker.sv]
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on plep_pkg and packed_list_entry_parser_defines.svh.
`include "packed_list_entry_parser_defines.svh"

module plep_checker import plep_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    `PLEP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result item changed while stalled")

    `PLEP_ASSERT_IMP(a_err_code, i_clk, i_rst_n, i_out_valid, (i_out_data.result_kind == KIND_ERROR) == (i_out_data.error_code != ERR_NONE), "error code does not match result kind")

    `PLEP_ASSERT_IMP(a_str_end, i_clk, i_rst_n, i_out_valid && i_out_data.string_end, i_out_data.result_kind == KIND_STR_BYTE, "string end on a non-string item")

    `PLEP_ASSERT_IMP(a_err_last, i_clk, i_rst_n, i_out_valid && (i_out_data.result_kind == KIND_ERROR), i_out_data.run_last, "error is not the last item of its byte")

endmodule

bind packed_list_entry_parser plep_checker u_plep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
